FILE: design/mbq_pkg.sv
`default_nettype none

package mbq_pkg;

    localparam int CHAN_W     = 3;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_COEF0 = 3'd0,
        REG_FF_COEF1 = 3'd1,
        REG_FF_COEF2 = 3'd2,
        REG_FB_COEF1 = 3'd3,
        REG_FB_COEF2 = 3'd4,
        REG_BYPASS   = 3'd5
    } cfg_reg_t;

    localparam logic [COEF_W-1:0] FF_COEF0_RESET = 32'd67108864;
    localparam logic [COEF_W-1:0] COEF_ZERO      = 32'd0;
    localparam logic              BYPASS_RESET   = 1'b1;

endpackage

`default_nettype wire

FILE: design/mbq_in_if.sv
`default_nettype none

interface mbq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [mbq_pkg::CHAN_W-1:0]    channel_in;
    logic                          frame_end_in;

    modport source (
        output valid,
        output sample_in,
        output channel_in,
        output frame_end_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_in,
        input  channel_in,
        input  frame_end_in,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/mbq_out_if.sv
`default_nettype none

interface mbq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [mbq_pkg::CHAN_W-1:0]    channel_out;
    logic                          frame_end_out;
    logic                          clipped;

    modport source (
        output valid,
        output sample_out,
        output channel_out,
        output frame_end_out,
        output clipped,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_out,
        input  channel_out,
        input  frame_end_out,
        input  clipped,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/multichannel_biquad_filter.sv
// Multichannel direct form I biquad. Each input beat carries a signed sample and a
// channel number; the block returns one output beat per input, in order, computing
// y = c0*x + c1*x1 + c2*x2 - d1*y1 - d2*y2 with that channel's own history. Coefficients
// are signed Q5.26 (COEF_FRAC_BITS fraction bits); the exact sum is rounded half up,
// shifted down and saturated to SAMPLE_BITS, with clipped set when saturation hit.
// Channels at or above CHANNELS use history set channel modulo CHANNELS. Bypass (the
// reset state) passes samples unchanged and freezes the histories. The datapath is an
// input register, one pass of five parallel multipliers with an adder, rounding and
// saturation, then an output register: one beat per cycle sustained unless the output
// stalls, and the history of a channel is updated as its result is registered, so
// consecutive beats of the same channel need no spacing. Coefficients and bypass are to
// be written by the user through the cfg port only while no beat is in flight; the
// block does not enforce this. Reset clears all histories at once.
`default_nettype none

module multichannel_biquad_filter #(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 26
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    mbq_in_if.sink                                in_stream,
    mbq_out_if.source                             out_stream,
    input  wire logic                             cfg_write,
    input  wire logic [mbq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mbq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RED_W  = 7;
    localparam int PROD_W = mbq_pkg::COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // configuration
    logic signed [mbq_pkg::COEF_W-1:0] ff_coef0_reg;
    logic signed [mbq_pkg::COEF_W-1:0] ff_coef1_reg;
    logic signed [mbq_pkg::COEF_W-1:0] ff_coef2_reg;
    logic signed [mbq_pkg::COEF_W-1:0] fb_coef1_reg;
    logic signed [mbq_pkg::COEF_W-1:0] fb_coef2_reg;
    logic                              bypass_reg;

    // input stage
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [mbq_pkg::CHAN_W-1:0]    s1_chan_reg;
    logic                          s1_frame_reg;

    // output stage
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [mbq_pkg::CHAN_W-1:0]    out_chan_reg;
    logic                          out_frame_reg;
    logic                          out_clip_reg;

    // per-channel history
    logic signed [SAMPLE_BITS-1:0] x1_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] x2_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y1_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y2_reg [CHANNELS];

    logic                          s2_load;
    logic                          s1_advance;
    logic                          in_fire;
    logic [RED_W-1:0]              chan_red;
    logic [IDX_W-1:0]              hidx;
    logic signed [SAMPLE_BITS-1:0] hx1;
    logic signed [SAMPLE_BITS-1:0] hx2;
    logic signed [SAMPLE_BITS-1:0] hy1;
    logic signed [SAMPLE_BITS-1:0] hy2;
    logic signed [PROD_W-1:0]      p0;
    logic signed [PROD_W-1:0]      p1;
    logic signed [PROD_W-1:0]      p2;
    logic signed [PROD_W-1:0]      p3;
    logic signed [PROD_W-1:0]      p4;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_rnd;
    logic [SH_W-1:0]               q;
    logic                          ovf_hi;
    logic                          ovf_lo;
    logic signed [SAMPLE_BITS-1:0] filt;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          clip_next;

    assign s2_load    = !out_valid_reg || out_stream.ready;
    assign s1_advance = s1_valid_reg && s2_load;
    assign in_fire    = in_stream.valid && in_stream.ready;

    assign in_stream.ready        = !s1_valid_reg || s2_load;
    assign out_stream.valid       = out_valid_reg;
    assign out_stream.sample_out  = out_sample_reg;
    assign out_stream.channel_out = out_chan_reg;
    assign out_stream.frame_end_out = out_frame_reg;
    assign out_stream.clipped     = out_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_coef0_reg <= mbq_pkg::FF_COEF0_RESET;
            ff_coef1_reg <= mbq_pkg::COEF_ZERO;
            ff_coef2_reg <= mbq_pkg::COEF_ZERO;
            fb_coef1_reg <= mbq_pkg::COEF_ZERO;
            fb_coef2_reg <= mbq_pkg::COEF_ZERO;
            bypass_reg   <= mbq_pkg::BYPASS_RESET;
        end
        else if (cfg_write)
        begin
            case (mbq_pkg::cfg_reg_t'(cfg_index))
                mbq_pkg::REG_FF_COEF0: ff_coef0_reg <= cfg_data;
                mbq_pkg::REG_FF_COEF1: ff_coef1_reg <= cfg_data;
                mbq_pkg::REG_FF_COEF2: ff_coef2_reg <= cfg_data;
                mbq_pkg::REG_FB_COEF1: fb_coef1_reg <= cfg_data;
                mbq_pkg::REG_FB_COEF2: fb_coef2_reg <= cfg_data;
                mbq_pkg::REG_BYPASS:   bypass_reg   <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_stream.ready)
            begin
                s1_valid_reg <= in_stream.valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= in_stream.sample_in;
            s1_chan_reg   <= in_stream.channel_in;
            s1_frame_reg  <= in_stream.frame_end_in;
        end
        if (s1_advance)
        begin
            out_sample_reg <= y_next;
            out_chan_reg   <= s1_chan_reg;
            out_frame_reg  <= s1_frame_reg;
            out_clip_reg   <= clip_next;
        end
    end

    // channel modulo CHANNELS by repeated subtract, channel is only 3 bits
    always_comb
    begin
        chan_red = RED_W'(s1_chan_reg);
        for (int i = 0; i < 8; i++)
        begin
            if (chan_red >= RED_W'(CHANNELS))
            begin
                chan_red = chan_red - RED_W'(CHANNELS);
            end
        end
    end

    assign hidx = chan_red[IDX_W-1:0];
    assign hx1  = x1_reg[hidx];
    assign hx2  = x2_reg[hidx];
    assign hy1  = y1_reg[hidx];
    assign hy2  = y2_reg[hidx];

    always_comb
    begin
        p0 = PROD_W'(ff_coef0_reg) * PROD_W'(s1_sample_reg);
        p1 = PROD_W'(ff_coef1_reg) * PROD_W'(hx1);
        p2 = PROD_W'(ff_coef2_reg) * PROD_W'(hx2);
        p3 = PROD_W'(fb_coef1_reg) * PROD_W'(hy1);
        p4 = PROD_W'(fb_coef2_reg) * PROD_W'(hy2);
        acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);
        acc_rnd = acc + $signed(ROUND_HALF);
        q = acc_rnd[ACC_W-1:COEF_FRAC_BITS];
        // out of range when the bits above the sample do not all match the sign
        ovf_hi = !q[SH_W-1] && (|q[SH_W-2:SAMPLE_BITS-1]);
        ovf_lo = q[SH_W-1] && !(&q[SH_W-2:SAMPLE_BITS-1]);
        if (ovf_hi)
        begin
            filt = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (ovf_lo)
        begin
            filt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            filt = q[SAMPLE_BITS-1:0];
        end
        if (bypass_reg)
        begin
            y_next    = s1_sample_reg;
            clip_next = 1'b0;
        end
        else
        begin
            y_next    = filt;
            clip_next = ovf_hi || ovf_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (s1_advance && !bypass_reg)
        begin
            x1_reg[hidx] <= s1_sample_reg;
            x2_reg[hidx] <= hx1;
            y1_reg[hidx] <= filt;
            y2_reg[hidx] <= hy1;
        end
    end

endmodule

`default_nettype wire

FILE: design/mbq_checker.sv
`default_nettype none

module mbq_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [SAMPLE_BITS-1:0]        sample_out,
    input wire logic [mbq_pkg::CHAN_W-1:0]    channel_out,
    input wire logic                          frame_end_out,
    input wire logic                          clipped
);

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic       in_beat;
    logic       out_beat;
    logic [1:0] flight_reg;
    logic [1:0] flight_next;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        flight_next = flight_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= 2'd0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)
            && $stable(channel_out) && $stable(frame_end_out) && $stable(clipped)))
        else $error("output beat changed while stalled");

    // a clipped result sits on a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |-> (sample_out == SMAX || sample_out == SMIN))
        else $error("clipped result not at saturation limit");

    // at most two beats inside, never an output beat without an input behind it
    a_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (flight_reg != 2'd3) && (!out_valid || flight_reg != 2'd0))
        else $error("beat count between ports inconsistent");

    // a draining output never backs up the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is taken");

endmodule

bind multichannel_biquad_filter mbq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mbq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_stream.valid),
    .in_ready      (in_stream.ready),
    .out_valid     (out_stream.valid),
    .out_ready     (out_stream.ready),
    .sample_out    (out_stream.sample_out),
    .channel_out   (out_stream.channel_out),
    .frame_end_out (out_stream.frame_end_out),
    .clipped       (out_stream.clipped)
);

`default_nettype wire

FILE: verif/multichannel_biquad_filter_test.sv
`default_nettype none

module multichannel_biquad_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS  = 8;
    localparam int SB        = 24;
    localparam int FRAC_BITS = 26;

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    localparam int COEF_ONE  = 32'sh0400_0000;
    localparam int COEF_HALF = 32'sh0200_0000;
    localparam int COEF_MAX  = 32'sh7fff_ffff;
    localparam int COEF_MIN  = 32'sh8000_0000;
    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);

    // indexes past the last register, writes there must be dropped
    localparam logic [mbq_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [mbq_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum int {COEF_TAME, COEF_WIDE, COEF_EDGE, COEF_RINGING} coef_style_t;

    typedef struct packed {
        logic signed [SB-1:0]         sample;
        logic [mbq_pkg::CHAN_W-1:0]   channel;
        logic                         frame_end;
    } filter_item_t;

    typedef struct packed {
        logic signed [SB-1:0]         sample;
        logic [mbq_pkg::CHAN_W-1:0]   channel;
        logic                         frame_end;
        logic                         clipped;
    } filter_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write;
    logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mbq_pkg::CFG_DATA_W-1:0] cfg_data;

    mbq_in_if  #(.SAMPLE_BITS(SB)) in_if ();
    mbq_out_if #(.SAMPLE_BITS(SB)) out_if ();

    multichannel_biquad_filter #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_BITS    (SB),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // filter settings and per-channel history as the block should hold them
    int                   ff_coef0 = COEF_ONE;
    int                   ff_coef1 = 0;
    int                   ff_coef2 = 0;
    int                   fb_coef1 = 0;
    int                   fb_coef2 = 0;
    logic                 bypass_on = 1'b1;
    logic signed [SB-1:0] in_hist1 [CHANNELS] = '{default: '0};
    logic signed [SB-1:0] in_hist2 [CHANNELS] = '{default: '0};
    logic signed [SB-1:0] out_hist1 [CHANNELS] = '{default: '0};
    logic signed [SB-1:0] out_hist2 [CHANNELS] = '{default: '0};

    filter_item_t   pending_samples [$];
    filter_result_t expected_results [$];

    int beats_offered = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;
    int in_gap        = 0;
    int out_stall     = 0;
    int in_idle_rate  = 3;
    int out_idle_rate = 3;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic filter_result_t biquad_filter_sample(input filter_item_t item);
        filter_result_t res;
        longint         acc;
        int             ch;
        ch = int'(item.channel) % CHANNELS;
        res.channel   = item.channel;
        res.frame_end = item.frame_end;
        res.clipped   = 1'b0;
        if (bypass_on)
        begin
            res.sample = item.sample;
        end
        else
        begin
            acc = longint'(ff_coef0) * longint'($signed(item.sample))
                + longint'(ff_coef1) * longint'(in_hist1[ch])
                + longint'(ff_coef2) * longint'(in_hist2[ch])
                - longint'(fb_coef1) * longint'(out_hist1[ch])
                - longint'(fb_coef2) * longint'(out_hist2[ch]);
            // round half up, then floor shift
            acc = (acc + ROUND_HALF) >>> FRAC_BITS;
            if (acc > SAMPLE_MAX)
            begin
                res.sample  = SAMPLE_MAX;
                res.clipped = 1'b1;
            end
            else if (acc < SAMPLE_MIN)
            begin
                res.sample  = SAMPLE_MIN;
                res.clipped = 1'b1;
            end
            else
            begin
                res.sample = acc[SB-1:0];
            end
            in_hist2[ch]  = in_hist1[ch];
            in_hist1[ch]  = item.sample;
            out_hist2[ch] = out_hist1[ch];
            out_hist1[ch] = res.sample;
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void queue_sample(input logic signed [SB-1:0] sample,
                                         input int channel, input logic frame_end);
        filter_item_t item;
        item.sample    = sample;
        item.channel   = channel[mbq_pkg::CHAN_W-1:0];
        item.frame_end = frame_end;
        pending_samples.push_back(item);
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] s;
        case ($urandom_range(0, 15))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2, 3:    s = SB'(int'($urandom_range(0, 512)) - 256);
            default: s = SB'($urandom());
        endcase
        return s;
    endfunction

    function automatic int pick_coef(input coef_style_t style);
        int c;
        case (style)
            COEF_TAME: c = int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
            COEF_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0:       c = COEF_MAX;
                    1:       c = COEF_MIN;
                    2:       c = 0;
                    3:       c = COEF_ONE;
                    default: c = -COEF_ONE;
                endcase
            end
            default:   c = $urandom();
        endcase
        return c;
    endfunction

    // one register per falling edge, write enable left high for the next one
    task automatic write_reg(input logic [mbq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbq_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            mbq_pkg::REG_FF_COEF0: ff_coef0  = data;
            mbq_pkg::REG_FF_COEF1: ff_coef1  = data;
            mbq_pkg::REG_FF_COEF2: ff_coef2  = data;
            mbq_pkg::REG_FB_COEF1: fb_coef1  = data;
            mbq_pkg::REG_FB_COEF2: fb_coef2  = data;
            mbq_pkg::REG_BYPASS:   bypass_on = data[0];
            default:               ;
        endcase
    endtask

    task automatic program_filter(input int c0, input int c1, input int c2, input int d1,
                                  input int d2,
                                  input logic [mbq_pkg::CFG_DATA_W-1:0] bypass_word);
        write_reg(mbq_pkg::REG_FF_COEF0, c0);
        write_reg(mbq_pkg::REG_FF_COEF1, c1);
        write_reg(mbq_pkg::REG_FF_COEF2, c2);
        write_reg(mbq_pkg::REG_FB_COEF1, d1);
        write_reg(mbq_pkg::REG_FB_COEF2, d2);
        write_reg(mbq_pkg::REG_BYPASS, bypass_word);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || beats_offered != beats_taken
               || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        filter_item_t next_item;
        if (rst_n && beats_offered == beats_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_if.valid <= 1'b0;
            end
            else if (pending_samples.size() == 0)
            begin
                in_if.valid <= 1'b0;
            end
            else
            begin
                next_item = pending_samples.pop_front();
                in_if.valid        <= 1'b1;
                in_if.sample_in    <= next_item.sample;
                in_if.channel_in   <= next_item.channel;
                in_if.frame_end_in <= next_item.frame_end;
                beats_offered++;
                if (in_idle_rate != 0 && $urandom_range(1, 16) <= in_idle_rate)
                    in_gap = $urandom_range(1, 6);
            end
        end
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                out_stall--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
                if (out_idle_rate != 0 && $urandom_range(1, 16) <= out_idle_rate)
                    out_stall = $urandom_range(1, 6);
            end
        end
    end

    // output check first, then predict the beat taken at this edge
    always @(posedge clk)
    begin
        filter_result_t got;
        filter_result_t want;
        filter_item_t   taken;
        logic           moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                moved = 1'b1;
                got.sample    = out_if.sample_out;
                got.channel   = out_if.channel_out;
                got.frame_end = out_if.frame_end_out;
                got.clipped   = out_if.clipped;
                if (expected_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected output beat, sample %0d channel %0d",
                                         $signed(got.sample), got.channel));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.sample !== want.sample)
                        flag_error($sformatf("beat %0d sample_out %0d, expected %0d",
                                             results_seen, $signed(got.sample),
                                             $signed(want.sample)));
                    if (got.channel !== want.channel)
                        flag_error($sformatf("beat %0d channel_out %0d, expected %0d",
                                             results_seen, got.channel, want.channel));
                    if (got.frame_end !== want.frame_end)
                        flag_error($sformatf("beat %0d frame_end_out %0b, expected %0b",
                                             results_seen, got.frame_end, want.frame_end));
                    if (got.clipped !== want.clipped)
                        flag_error($sformatf("beat %0d clipped %0b, expected %0b",
                                             results_seen, got.clipped, want.clipped));
                end
                results_seen++;
            end
            if (in_if.valid && in_if.ready)
            begin
                moved = 1'b1;
                taken.sample    = in_if.sample_in;
                taken.channel   = in_if.channel_in;
                taken.frame_end = in_if.frame_end_in;
                expected_results.push_back(biquad_filter_sample(taken));
                beats_taken++;
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("multichannel_biquad_filter_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        coef_style_t                    style;
        logic [mbq_pkg::CFG_DATA_W-1:0] bypass_word;
        int                             chan;

        in_if.valid        = 1'b0;
        in_if.sample_in    = '0;
        in_if.channel_in   = '0;
        in_if.frame_end_in = 1'b0;
        out_if.ready       = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // bypass out of reset: samples pass, histories stay frozen
        queue_sample(SAMPLE_MAX, 0, 1'b1);
        queue_sample(SAMPLE_MIN, 7, 1'b0);
        queue_sample(0, 3, 1'b1);
        queue_sample(-1, 5, 1'b0);
        wait_drained();

        // unity filter, spare register indexes written with junk
        write_reg(REG_SPARE_A, 32'hffff_ffff);
        write_reg(REG_SPARE_B, 32'h8000_0001);
        program_filter(COEF_ONE, 0, 0, 0, 0, 32'h0000_0000);
        queue_sample(SAMPLE_MAX, 0, 1'b0);
        queue_sample(SAMPLE_MIN, 1, 1'b1);
        queue_sample(1, 2, 1'b0);
        queue_sample(-1, 2, 1'b1);
        wait_drained();

        // half gain: ties round toward positive infinity
        program_filter(COEF_HALF, 0, 0, 0, 0, 32'hffff_fffe);
        queue_sample(1, 3, 1'b0);
        queue_sample(-1, 3, 1'b0);
        queue_sample(3, 4, 1'b0);
        queue_sample(-3, 4, 1'b1);
        wait_drained();

        // extreme coefficients drive saturation both ways
        program_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 32'h0);
        queue_sample(SAMPLE_MAX, 5, 1'b1);
        queue_sample(SAMPLE_MIN, 5, 1'b0);
        queue_sample(SAMPLE_MAX, 6, 1'b0);
        queue_sample(0, 6, 1'b1);
        queue_sample(SAMPLE_MIN, 6, 1'b0);
        wait_drained();

        // bypass again, then resume on the frozen histories
        write_reg(mbq_pkg::REG_BYPASS, 32'hffff_ffff);
        @(negedge clk);
        cfg_write <= 1'b0;
        queue_sample(12345, 6, 1'b0);
        queue_sample(-7, 5, 1'b1);
        wait_drained();
        program_filter(COEF_ONE, COEF_HALF, -COEF_HALF, -(COEF_ONE / 4), COEF_ONE / 8, 32'h0);
        queue_sample(1000, 5, 1'b0);
        queue_sample(-1000, 6, 1'b1);
        queue_sample(SAMPLE_MAX, 5, 1'b0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            style = coef_style_t'($urandom_range(0, 3));
            bypass_word    = $urandom();
            bypass_word[0] = (phase == 2) || ($urandom_range(0, 7) == 0);
            if (style == COEF_RINGING)
                program_filter(int'($urandom_range(0, COEF_ONE / 64)), 0, 0,
                               -2 * COEF_ONE + int'($urandom_range(0, COEF_ONE / 8)),
                               COEF_ONE - int'($urandom_range(0, COEF_ONE / 16)),
                               bypass_word);
            else
                program_filter(pick_coef(style), pick_coef(style), pick_coef(style),
                               pick_coef(style), pick_coef(style), bypass_word);
            // last phases run at full rate
            if (phase >= RANDOM_PHASES - 2)
            begin
                in_idle_rate  = 0;
                out_idle_rate = 0;
            end
            else
            begin
                in_idle_rate  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                out_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            chan = $urandom_range(0, CHANNELS - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // runs on one channel build up its history
                if ($urandom_range(0, 1) == 0)
                    chan = $urandom_range(0, CHANNELS - 1);
                queue_sample(pick_sample(), chan, 1'($urandom_range(0, 1)));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("multichannel_biquad_filter_test: done, clean");
        else
            $display("multichannel_biquad_filter_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
